// ===== design/cta_pkg.sv =====
// ----------------------------------------------------------------------------
// cta_pkg
// Shared types, unit and operation codes, and the calendar helper functions
// for the clock time and alarm setter.
// ----------------------------------------------------------------------------
package cta_pkg;

    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 32;

    typedef logic [6:0] tval_t;
    typedef logic [5:0] aval_t;
    typedef logic [6:0][6:0] tfields_t;
    typedef logic [2:0][5:0] afields_t;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_UP    = 3'd1,
        OP_DOWN  = 3'd2,
        OP_ENTER = 3'd3,
        OP_MODE  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        MODE_CLOCK     = 3'b001,
        MODE_SET_TIME  = 3'b010,
        MODE_SET_ALARM = 3'b100
    } mode_t;

    localparam logic [1:0] MODE_CODE_CLOCK     = 2'd0;
    localparam logic [1:0] MODE_CODE_SET_TIME  = 2'd1;
    localparam logic [1:0] MODE_CODE_SET_ALARM = 2'd2;

    localparam logic [2:0] UNIT_YEAR   = 3'd0;
    localparam logic [2:0] UNIT_MONTH  = 3'd1;
    localparam logic [2:0] UNIT_DATE   = 3'd2;
    localparam logic [2:0] UNIT_DAY    = 3'd3;
    localparam logic [2:0] UNIT_HOUR   = 3'd4;
    localparam logic [2:0] UNIT_MINUTE = 3'd5;
    localparam logic [2:0] UNIT_SECOND = 3'd6;

    localparam logic [1:0] ALARM_HOUR   = 2'd0;
    localparam logic [1:0] ALARM_MINUTE = 2'd1;
    localparam logic [1:0] ALARM_SECOND = 2'd2;

    localparam tval_t MONTHS_PER_YEAR = 7'd12;
    localparam tval_t FEB             = 7'd2;
    localparam tval_t FEB_LEAP_DAY    = 7'd29;
    localparam tval_t FEB_SHORT       = 7'd28;
    localparam tval_t LONG_MONTH      = 7'd31;

    // Year 0, month, date and weekday 1, time of day midnight.
    localparam tfields_t COMMITTED_INIT = {7'd0, 7'd0, 7'd0, 7'd1, 7'd1, 7'd1, 7'd0};

    typedef struct packed {
        logic       alarm_match;
        logic       rtc_update;
        tval_t      commit_value;
        logic [2:0] commit_unit;
        logic       commit_is_alarm;
        logic       commit_valid;
        tval_t      selected_value;
        logic [2:0] selected_unit;
        logic [1:0] mode;
    } res_t;

    localparam int RES_W = $bits(res_t);

    function automatic tval_t field_max(input logic [2:0] unit);
        case (unit)
            UNIT_YEAR:   field_max = 7'd99;
            UNIT_MONTH:  field_max = 7'd12;
            UNIT_DATE:   field_max = 7'd31;
            UNIT_DAY:    field_max = 7'd7;
            UNIT_HOUR:   field_max = 7'd23;
            default:     field_max = 7'd59;
        endcase
    endfunction

    function automatic tval_t alarm_max(input logic [1:0] idx);
        case (idx)
            ALARM_HOUR: alarm_max = 7'd23;
            default:    alarm_max = 7'd59;
        endcase
    endfunction

    function automatic tval_t month_len(input logic [3:0] m);
        case (m)
            4'd2:                      month_len = 7'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   month_len = 7'd30;
            default:                   month_len = 7'd31;
        endcase
    endfunction

    // Two-digit years: every year divisible by four is a leap year.
    function automatic tval_t days_of(input tval_t m, input tval_t y);
        if (m == 7'd0 || m > MONTHS_PER_YEAR) begin
            days_of = LONG_MONTH;
        end else if (m == FEB && y[1:0] == 2'd0) begin
            days_of = FEB_LEAP_DAY;
        end else begin
            days_of = month_len(m[3:0]);
        end
    endfunction

    // (v + 1) mod (mx + 1); reachable values never exceed twice the modulus.
    function automatic tval_t wrap_up(input tval_t v, input tval_t mx);
        logic [7:0] t;
        logic [7:0] m;
        t = {1'b0, v} + 8'd1;
        m = {1'b0, mx} + 8'd1;
        if (t >= m) begin
            wrap_up = tval_t'(t - m);
        end else begin
            wrap_up = tval_t'(t);
        end
    endfunction

    function automatic tval_t wrap_down(input tval_t v, input tval_t mx);
        wrap_down = (v == 7'd0) ? mx : v - 7'd1;
    endfunction

endpackage

// ===== design/clock_time_alarm_setter.sv =====
// ----------------------------------------------------------------------------
// clock_time_alarm_setter
// Clock, time-setting and alarm-setting controller driven by button beats.
// ----------------------------------------------------------------------------
// A result beat is registered in the result queue before m_tvalid offers it.
// Throughput: one beat per cycle while s_tready is high; the mode and field logic
// settles between the state registers and a two-entry result queue.
// s_tready drops only when both result queue entries are waiting.
// Reset (aresetn low, synchronous): clock mode, first field selected, time
// settings year 0 / month, date, weekday 1 / midnight, alarm at midnight.
// ----------------------------------------------------------------------------
module clock_time_alarm_setter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[2:0], rtc_hour[7:3], rtc_minute[13:8], rtc_second[19:14], zero fill
    input  logic [cta_pkg::TDATA_IN_W-1:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // mode[1:0], selected_unit[4:2], selected_value[11:5], commit_valid[12],
    // commit_is_alarm[13], commit_unit[16:14], commit_value[23:17],
    // rtc_update[24], alarm_match[25], zero fill
    output logic [cta_pkg::TDATA_OUT_W-1:0] m_tdata
);
    import cta_pkg::*;

    localparam int PAD_W = TDATA_OUT_W - RES_W;

    mode_t      mode_reg, mode_next;
    logic [2:0] sel_reg, sel_next;
    logic       pend_reg, pend_next;
    tfields_t   edit_reg, edit_next;
    tfields_t   comm_reg, comm_next;
    afields_t   aedit_reg, aedit_next;
    afields_t   alarm_reg, alarm_next;

    op_t        op;
    aval_t      rtc_h, rtc_m, rtc_s;
    tfields_t   e_cur;
    afields_t   a_cur;
    logic [2:0] sel_t;
    logic [1:0] sel_a;
    logic [2:0] sel_out;
    res_t       res;
    logic       accept;
    res_t       q_data;

    // One edit of the time copy, with month-length and leap-year corrections.
    function automatic tfields_t edit_time(input tfields_t e, input logic up,
                                           input logic [2:0] s);
        tfields_t n;
        tval_t    md;
        tval_t    md2;
        tval_t    t;
        n  = e;
        md = days_of(e[UNIT_MONTH], e[UNIT_YEAR]);
        t  = up ? wrap_up(e[s], field_max(s)) : wrap_down(e[s], field_max(s));
        n[s] = t;
        case (s)
            UNIT_DATE: begin
                if (up) begin
                    if (t == 7'd0 || t > md) begin
                        n[UNIT_DATE] = 7'd1;
                    end
                end else if (t == 7'd0) begin
                    n[UNIT_DATE] = md;
                end
            end
            UNIT_DAY: begin
                if (t == 7'd0) begin
                    n[UNIT_DAY] = up ? 7'd1 : field_max(UNIT_DAY);
                end
            end
            UNIT_MONTH: begin
                if (up) begin
                    if (t == 7'd0 || t > MONTHS_PER_YEAR) begin
                        n[UNIT_MONTH] = 7'd1;
                    end
                end else if (t == 7'd0) begin
                    n[UNIT_MONTH] = MONTHS_PER_YEAR;
                end
                md2 = days_of(n[UNIT_MONTH], e[UNIT_YEAR]);
                if (e[UNIT_DATE] > md2) begin
                    n[UNIT_DATE] = md2;
                end
            end
            UNIT_YEAR: begin
                // A leap day cannot survive a move to a common year.
                if (e[UNIT_MONTH] == FEB && e[UNIT_DATE] == FEB_LEAP_DAY &&
                    t[1:0] != 2'd0) begin
                    n[UNIT_DATE] = FEB_SHORT;
                end
            end
            default: begin
            end
        endcase
        return n;
    endfunction

    assign op     = op_t'(s_tdata[2:0]);
    assign rtc_h  = {1'b0, s_tdata[7:3]};
    assign rtc_m  = s_tdata[13:8];
    assign rtc_s  = s_tdata[19:14];
    assign accept = s_tvalid && s_tready;

    always_comb begin
        for (int i = 0; i < 7; i++) begin
            e_cur[i] = pend_reg ? comm_reg[i] : edit_reg[i];
        end
        a_cur = pend_reg ? {rtc_s, rtc_m, rtc_h} : aedit_reg;
        sel_t = (sel_reg > UNIT_SECOND) ? UNIT_YEAR : sel_reg;
        sel_a = (sel_reg > 3'(ALARM_SECOND)) ? ALARM_HOUR : sel_reg[1:0];

        mode_next  = mode_reg;
        sel_next   = sel_reg;
        pend_next  = pend_reg;
        edit_next  = e_cur;
        comm_next  = comm_reg;
        aedit_next = a_cur;
        alarm_next = alarm_reg;
        res        = '0;

        case (mode_reg)
            MODE_SET_TIME: begin
                pend_next = 1'b0;
                sel_next  = sel_t;
                case (op)
                    OP_UP, OP_DOWN: begin
                        edit_next = edit_time(e_cur, op == OP_UP, sel_t);
                    end
                    OP_ENTER: begin
                        comm_next[sel_t]    = e_cur[sel_t];
                        res.commit_valid    = 1'b1;
                        res.commit_unit     = sel_t;
                        res.commit_value    = e_cur[sel_t];
                        sel_next = (sel_t == UNIT_SECOND) ? UNIT_YEAR : sel_t + 3'd1;
                    end
                    OP_MODE: begin
                        res.rtc_update = 1'b1;
                        pend_next      = 1'b1;
                        mode_next      = MODE_SET_ALARM;
                        sel_next       = 3'd0;
                    end
                    default: begin
                    end
                endcase
            end
            MODE_SET_ALARM: begin
                pend_next = 1'b0;
                sel_next  = {1'b0, sel_a};
                case (op)
                    OP_UP: begin
                        aedit_next[sel_a] = aval_t'(wrap_up({1'b0, a_cur[sel_a]},
                                                            alarm_max(sel_a)));
                    end
                    OP_DOWN: begin
                        aedit_next[sel_a] = aval_t'(wrap_down({1'b0, a_cur[sel_a]},
                                                              alarm_max(sel_a)));
                    end
                    OP_ENTER: begin
                        res.commit_valid    = 1'b1;
                        res.commit_is_alarm = 1'b1;
                        res.commit_unit     = {1'b0, sel_a} + UNIT_HOUR;
                        res.commit_value    = {1'b0, a_cur[sel_a]};
                        alarm_next          = a_cur;
                        sel_next = (sel_a == ALARM_SECOND) ? 3'd0 : {1'b0, sel_a} + 3'd1;
                    end
                    OP_MODE: begin
                        mode_next = MODE_CLOCK;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                res.alarm_match = (rtc_h == alarm_reg[ALARM_HOUR]) &&
                                  (rtc_m == alarm_reg[ALARM_MINUTE]) &&
                                  (rtc_s == alarm_reg[ALARM_SECOND]);
                if (op == OP_MODE) begin
                    pend_next = 1'b1;
                    mode_next = MODE_SET_TIME;
                    sel_next  = 3'd0;
                end
            end
        endcase

        // The displayed field reflects the state after this beat.
        sel_out = 3'd0;
        case (mode_next)
            MODE_SET_TIME: begin
                sel_out            = (sel_next > UNIT_SECOND) ? UNIT_YEAR : sel_next;
                res.mode           = MODE_CODE_SET_TIME;
                res.selected_unit  = sel_out;
                res.selected_value = pend_next ? 7'd0 : edit_next[sel_out];
            end
            MODE_SET_ALARM: begin
                sel_out            = (sel_next > 3'(ALARM_SECOND)) ? 3'd0 : sel_next;
                res.mode           = MODE_CODE_SET_ALARM;
                res.selected_unit  = sel_out + UNIT_HOUR;
                res.selected_value = pend_next ? 7'd0 : {1'b0, aedit_next[sel_out[1:0]]};
            end
            default: begin
                res.mode = MODE_CODE_CLOCK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_CLOCK;
            sel_reg   <= 3'd0;
            pend_reg  <= 1'b1;
            comm_reg  <= COMMITTED_INIT;
            alarm_reg <= '0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            sel_reg   <= sel_next;
            pend_reg  <= pend_next;
            comm_reg  <= comm_next;
            alarm_reg <= alarm_next;
        end
    end

    // Working copies are loaded on the first beat in their mode, before they are read.
    always_ff @(posedge aclk) begin
        if (accept && mode_reg == MODE_SET_TIME) begin
            edit_reg <= edit_next;
        end
        if (accept && mode_reg == MODE_SET_ALARM) begin
            aedit_reg <= aedit_next;
        end
    end

    cta_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (q_data)
    );

    assign m_tdata = {{PAD_W{1'b0}}, q_data};

endmodule

// ===== design/cta_outq.sv =====
// ----------------------------------------------------------------------------
// cta_outq
// Two-entry result queue. It lets the block take a new item while a result
// is still waiting downstream, with no combinational path from m_tready.
// ----------------------------------------------------------------------------
module cta_outq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  cta_pkg::res_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output cta_pkg::res_t out_data
);
    import cta_pkg::*;

    res_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = q_reg[rd_ptr_reg];

    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== design/cta_chk.sv =====
// ----------------------------------------------------------------------------
// cta_chk
// Port-level checks for the clock time and alarm setter, bound to the top.
// ----------------------------------------------------------------------------
module cta_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    localparam logic [1:0] CODE_CLOCK = 2'd0;
    localparam logic [1:0] CODE_ALARM = 2'd2;
    localparam logic [2:0] UNIT_ALARM_HOUR = 3'd4;

    logic [1:0] o_mode;
    logic [2:0] o_unit;
    logic [6:0] o_value;
    logic       o_cvalid;
    logic       o_calarm;
    logic [2:0] o_cunit;
    logic [6:0] o_cvalue;
    logic       o_update;

    assign o_mode   = m_tdata[1:0];
    assign o_unit   = m_tdata[4:2];
    assign o_value  = m_tdata[11:5];
    assign o_cvalid = m_tdata[12];
    assign o_calarm = m_tdata[13];
    assign o_cunit  = m_tdata[16:14];
    assign o_cvalue = m_tdata[23:17];
    assign o_update = m_tdata[24];

    // A stalled result beat must hold.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_no_commit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !o_cvalid |-> !o_calarm && o_cunit == 3'd0 && o_cvalue == 7'd0)
        else $error("commit fields set without a commit");

    a_clock_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && o_mode == CODE_CLOCK |-> o_unit == 3'd0 && o_value == 7'd0)
        else $error("field shown in clock mode");

    // Leaving time setting lands on a freshly entered alarm mode.
    a_update_to_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && o_update |->
            o_mode == CODE_ALARM && o_unit == UNIT_ALARM_HOUR && o_value == 7'd0 && !o_cvalid)
        else $error("clock update outside a move to alarm mode");

endmodule

bind clock_time_alarm_setter cta_chk u_cta_chk (.*);
